// ===== src/itrt_pkg.sv =====
// ---------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and the digit-to-character lookup for the
// integer to radix text converter.
// ---------------------------------------------------------------------------
package itrt_pkg;

   localparam int RADIX_W  = 6;
   localparam int DIGIT_W  = 6;
   localparam int CHAR_W   = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

   localparam logic [CHAR_W-1:0] MINUS_CHAR  = 7'h2d;
   localparam logic [CHAR_W-1:0] ZERO_CHAR   = 7'h30;
   localparam logic [CHAR_W-1:0] ALPHA_CHAR  = 7'h61;
   localparam logic [CHAR_W-1:0] ERROR_CHAR  = 7'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_DIV,
      ST_SIGN,
      ST_READ,
      ST_EMIT
   } state_type;

   // control from the sequencer to the serial divider
   typedef struct packed {
      logic load;
      logic start;
   } div_ctrl_type;

   // status back from the serial divider
   typedef struct packed {
      logic done;
      logic nonzero;
   } div_stat_type;

   // digit value 0..35 to ascii '0'..'9', 'a'..'z'
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {1'b0, d};
      if (d < DIGIT_W'(10))
         digit_char = ZERO_CHAR + dx;
      else
         digit_char = ALPHA_CHAR + dx - CHAR_W'(10);
   endfunction

endpackage

// ===== src/itrt_divider.sv =====
// ---------------------------------------------------------------------------
// itrt_divider
// Bit-serial restoring divider: one quotient bit per cycle. The dividend
// register shifts the quotient in behind it, so after a pass it holds the
// quotient, ready for the next pass.
// ---------------------------------------------------------------------------
module itrt_divider #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  itrt_pkg::div_ctrl_type       ctrl,
   input  logic [VALUE_WIDTH-1:0]       load_value,
   input  logic [itrt_pkg::RADIX_W-1:0] radix,
   output itrt_pkg::div_stat_type       stat,
   output logic [itrt_pkg::DIGIT_W-1:0] remainder
);
   import itrt_pkg::*;

   localparam int BIT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   nz_ff, nz_in;
   logic [DIGIT_W:0]       trial;
   logic [DIGIT_W:0]       diff;
   logic                   ge;
   logic                   final_bit;

   assign trial     = {rem_ff, value_ff[VALUE_WIDTH-1]};
   assign ge        = trial >= {1'b0, radix};
   assign diff      = trial - {1'b0, radix};
   assign final_bit = bit_cnt_ff == BIT_W'(VALUE_WIDTH - 1);

   always_comb begin
      value_in   = value_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      nz_in      = nz_ff;
      if (busy_ff) begin
         value_in   = {value_ff[VALUE_WIDTH-2:0], ge};
         rem_in     = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         nz_in      = nz_ff | ge;
         bit_cnt_in = bit_cnt_ff + BIT_W'(1);
         if (final_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (ctrl.load)
         value_in = load_value;
      if (ctrl.start) begin
         rem_in     = '0;
         bit_cnt_in = '0;
         busy_in    = 1'b1;
         nz_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      value_ff <= value_in;
      rem_ff   <= rem_in;
      nz_ff    <= nz_in;
   end

   assign stat.done    = done_ff;
   assign stat.nonzero = nz_ff;
   assign remainder    = rem_ff;

endmodule

// ===== src/itrt_digit_store.sv =====
// ---------------------------------------------------------------------------
// itrt_digit_store
// Digit memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module itrt_digit_store #(
   parameter int DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [itrt_pkg::DIGIT_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [itrt_pkg::DIGIT_W-1:0] rd_data
);
   import itrt_pkg::*;

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/integer_to_radix_text_core.sv =====
// ---------------------------------------------------------------------------
// integer_to_radix_text_core
// Converts a signed integer to ascii digits in base 2..36, one character per
// output transaction, most significant first.
// ---------------------------------------------------------------------------
// usage:
//   req channel carries number and radix. rsp channel returns one character
//   per transaction; rsp_last marks the final one. base ten negative numbers
//   start with '-', other bases treat the number as unsigned. a radix outside
//   2..36 gives a single transaction with character 0, last and bad_radix set.
// flow:
//   each digit is found by one pass of the bit-serial divider; the digits
//   are then read back through the registered digit memory read port, with
//   a read state followed by an emit state for each character.
//   one transaction is converted at a time; req_ready is high only between
//   conversions, and the last character may still wait in the output register
//   while the next transaction is accepted.
// reset:
//   synchronous reset empties the output register and returns to idle.
// stall:
//   a stalled rsp_ready holds the current character and pauses the emitter.
// ---------------------------------------------------------------------------
module integer_to_radix_text_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_number,
   input  logic [itrt_pkg::RADIX_W-1:0] req_radix,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [itrt_pkg::CHAR_W-1:0]  rsp_character,
   output logic                         rsp_last,
   output logic                         rsp_bad_radix
);
   import itrt_pkg::*;

   localparam int IDX_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   state_type state_ff, state_in;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               sign_ff, sign_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;
   logic [DIGIT_W-1:0] div_rem;
   logic [VALUE_WIDTH-1:0] magnitude;

   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [DIGIT_W-1:0] mem_rd_data;

   logic               req_accept;
   logic               slot_free;
   logic               bad_radix;
   logic               with_sign;
   logic [CNT_W-1:0]   count_dec;

   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign bad_radix  = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
   assign with_sign  = req_number[VALUE_WIDTH-1] && (req_radix == RADIX_DEC);
   assign magnitude  = with_sign ? (~req_number + VALUE_WIDTH'(1)) : req_number;
   assign count_dec  = count_ff - CNT_W'(1);

   itrt_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .load_value (magnitude),
      .radix      (radix_ff),
      .stat       (div_stat),
      .remainder  (div_rem)
   );

   itrt_digit_store #(
      .DEPTH(VALUE_WIDTH)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (div_rem),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept)
               state_in = bad_radix ? ST_ERR : ST_DIV;
         end
         ST_ERR: begin
            if (slot_free)
               state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_stat.done && !div_stat.nonzero)
               state_in = sign_ff ? ST_SIGN : ST_READ;
         end
         ST_SIGN: begin
            if (slot_free)
               state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free)
               state_in = (count_ff == CNT_W'(1)) ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready      = 1'b0;
      div_ctrl.load  = 1'b0;
      div_ctrl.start = 1'b0;
      mem_wr_en      = 1'b0;
      mem_rd_addr    = count_dec[IDX_W-1:0];
      radix_in       = radix_ff;
      sign_in        = sign_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_bad_in     = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_accept) begin
               radix_in       = req_radix;
               sign_in        = with_sign;
               count_in       = '0;
               div_ctrl.load  = 1'b1;
               div_ctrl.start = !bad_radix;
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ERROR_CHAR;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               mem_wr_en      = 1'b1;
               count_in       = count_ff + CNT_W'(1);
               div_ctrl.start = div_stat.nonzero;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = MINUS_CHAR;
               rsp_last_in  = 1'b0;
               rsp_bad_in   = 1'b0;
            end
         end
         ST_READ: begin
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_char(mem_rd_data);
               rsp_last_in  = count_ff == CNT_W'(1);
               rsp_bad_in   = 1'b0;
               count_in     = count_dec;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      radix_ff    <= radix_in;
      sign_ff     <= sign_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

   // error transaction is always a lone, empty, final character
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radix |-> rsp_last && (rsp_character == ERROR_CHAR))
      else $error("bad radix result not flagged last or not zero");

   // digit count never exceeds the value width
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VALUE_WIDTH))
      else $error("digit count overflow");

   // an accepted transaction always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start conversion");

   // emitting a digit needs at least one stored digit
   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_READ) |-> count_ff != '0)
      else $error("emit with empty digit store");

endmodule
